/* rtl/core/lmt_pkg.sv */
// lmt_pkg: shared types, codes and timing constants of the lcd mode timing unit
// no dependencies; imported by every module of the block
`default_nettype none

package lmt_pkg;

  // line and frame timing, in machine cycles and lines
  localparam logic [8:0] LINE_LEN        = 9'd456;
  localparam logic [7:0] LINES_PER_FRAME = 8'd154;
  localparam logic [7:0] VBLANK_LINE     = 8'd144;
  localparam logic [8:0] OAM_END         = 9'd80;
  localparam logic [8:0] XFER_END        = 9'd252;

  // stat enable bit positions
  localparam int unsigned EN_HBLANK = 0;
  localparam int unsigned EN_VBLANK = 1;
  localparam int unsigned EN_OAM    = 2;
  localparam int unsigned EN_COINC  = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_LCD_ON       = 2'd0;
  localparam logic [1:0] CFG_LINE_COMPARE = 2'd1;
  localparam logic [1:0] CFG_STAT_ENABLES = 2'd2;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_BLACK = 2'd2
  } line_req_t;

  typedef struct packed {
    logic       lcd_on;
    logic [7:0] line_compare;
    logic [3:0] stat_enables;
  } cfg_t;

  typedef struct packed {
    logic [7:0] line_number;
    mode_t      mode;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       frame_ready;
    line_req_t  line_request;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/lmt_cfg_regs.sv */
// lmt_cfg_regs: lcd control, line compare and stat enable registers
// depends on lmt_pkg
`default_nettype none

module lmt_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [1:0]   wr_index,
  input  wire logic [7:0]   wr_data,
  output lmt_pkg::cfg_t     cfg
);
  import lmt_pkg::*;

  cfg_t regs;

  // register write, values masked to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lcd_on       <= 1'b1;
      regs.line_compare <= 8'd0;
      regs.stat_enables <= 4'd0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_LCD_ON:       regs.lcd_on       <= wr_data[0];
        CFG_LINE_COMPARE: regs.line_compare <= wr_data;
        CFG_STAT_ENABLES: regs.stat_enables <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

/* rtl/core/lmt_timing.sv */
// lmt_timing: frame, line and mode counters with the one-step update logic
// depends on lmt_pkg; the frame count is kept as line number plus remainder
`default_nettype none

module lmt_timing (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   cycles,
  input  wire lmt_pkg::cfg_t cfg,
  output lmt_pkg::result_t  res_next
);
  import lmt_pkg::*;

  // frame position as line and cycle within line (frame = line*456 + rem)
  logic [7:0] line_q;
  logic [8:0] rem_q;
  logic [8:0] line_cycles_q;
  mode_t      mode_q;
  logic       match_q;

  logic [7:0] line_next;
  logic [8:0] rem_next;
  logic [8:0] line_cycles_next;
  mode_t      mode_next;
  logic       match_next;

  logic [9:0] rem_sum;
  logic       rem_carry;
  logic [7:0] line_inc;
  logic       wrap;
  logic [8:0] lc_base;
  logic [9:0] lc_sum;

  always_comb begin
    // advance the frame position
    rem_sum   = {1'b0, rem_q} + {2'b00, cycles};
    rem_carry = (rem_sum >= {1'b0, LINE_LEN});
    rem_next  = rem_carry ? 9'(rem_sum - {1'b0, LINE_LEN}) : rem_sum[8:0];
    line_inc  = line_q + {7'd0, rem_carry};
    wrap      = (line_inc == LINES_PER_FRAME);
    line_next = wrap ? 8'd0 : line_inc;
    // at frame wrap the line counter restarts from the new frame count
    lc_base   = wrap ? rem_next : line_cycles_q;
    lc_sum    = {1'b0, lc_base} + {2'b00, cycles};

    line_cycles_next = lc_base;
    mode_next        = mode_q;
    match_next       = match_q;

    res_next              = '0;
    res_next.line_request = REQ_NONE;

    // coincidence flag, frozen while the lcd is off
    if (cfg.lcd_on) begin
      if (line_next == cfg.line_compare) begin
        if (!match_q) begin
          match_next = 1'b1;
          if (cfg.stat_enables[EN_COINC]) res_next.stat_irq = 1'b1;
        end
      end else begin
        match_next = 1'b0;
      end
    end

    // mode walk
    if (line_next >= VBLANK_LINE) begin
      if (!mode_q[0]) begin
        mode_next            = MODE_VBLANK;
        res_next.frame_ready = 1'b1;
        res_next.vblank_irq  = 1'b1;
        if (cfg.stat_enables[EN_VBLANK]) res_next.stat_irq = 1'b1;
      end
    end else begin
      line_cycles_next = (lc_sum >= {1'b0, LINE_LEN}) ?
                         9'(lc_sum - {1'b0, LINE_LEN}) : lc_sum[8:0];
      if (line_cycles_next <= OAM_END) begin
        if (mode_q != MODE_OAM) begin
          mode_next = MODE_OAM;
          if (cfg.stat_enables[EN_OAM]) res_next.stat_irq = 1'b1;
        end
      end else if (line_cycles_next <= XFER_END) begin
        mode_next = MODE_XFER;
      end else begin
        if (mode_q != MODE_HBLANK) begin
          mode_next = MODE_HBLANK;
          if (cfg.stat_enables[EN_HBLANK]) res_next.stat_irq = 1'b1;
          res_next.line_request = cfg.lcd_on ? REQ_DRAW : REQ_BLACK;
        end
      end
    end

    res_next.line_number = line_next;
    res_next.mode        = mode_next;
    res_next.coincidence = match_next;
  end

  // timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_q        <= 8'd0;
      rem_q         <= 9'd0;
      line_cycles_q <= 9'd0;
      mode_q        <= MODE_HBLANK;
      match_q       <= 1'b0;
    end else if (step) begin
      line_q        <= line_next;
      rem_q         <= rem_next;
      line_cycles_q <= line_cycles_next;
      mode_q        <= mode_next;
      match_q       <= match_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcd_mode_timing_unit.sv */
// lcd_mode_timing_unit: lcd status and mode timing from elapsed cycle counts
// each input word passes through the input register and then the result register
// throughput: one word per cycle while the result is not stalled; the counter update loop is closed in lmt_timing
// reset (rst, synchronous): counters, mode and flags clear, lcd_on=1, other config 0
// a stalled result holds while the next word is still taken into the input register if that register is empty
// depends on lmt_pkg, lmt_cfg_regs, lmt_timing
`default_nettype none

module lcd_mode_timing_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] cycles,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      line_number,
  output logic [1:0]      mode,
  output logic            coincidence,
  output logic            vblank_irq,
  output logic            stat_irq,
  output logic            frame_ready,
  output logic [1:0]      line_request,
  // configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import lmt_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_cycles;
  logic       s1_fire;
  logic       in_fire;
  result_t    res_next;
  result_t    res_q;

  assign cfg_ready = 1'b1;

  lmt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake: the input register moves on whenever the result register frees up
  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cycles <= cycles;
    end
  end

  lmt_timing u_timing (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_fire),
    .cycles   (s1_cycles),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_q <= res_next;
    end
  end

  assign line_number  = res_q.line_number;
  assign mode         = res_q.mode;
  assign coincidence  = res_q.coincidence;
  assign vblank_irq   = res_q.vblank_irq;
  assign stat_irq     = res_q.stat_irq;
  assign frame_ready  = res_q.frame_ready;
  assign line_request = res_q.line_request;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled while pipeline has room");

  a_line_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_number < LINES_PER_FRAME))
    else $error("line number beyond frame");

  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_ready) |-> (vblank_irq && mode == MODE_VBLANK))
    else $error("frame ready without vblank entry");

  a_request_in_hblank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_request != REQ_NONE) |-> (mode == MODE_HBLANK))
    else $error("line request outside hblank entry");

endmodule

`default_nettype wire
